>>> design/ipd_pkg.sv
`default_nettype none

package ipd_pkg;

    localparam int unsigned EVENT_LIMIT_DEF = 4096;
    localparam int unsigned STAMP_W         = 32;
    localparam int unsigned MIN_W           = 17;
    localparam int unsigned RUN_W           = 13;
    localparam int unsigned DIGIT_W         = 8;

    localparam logic [MIN_W-1:0] MIN_EVENTS_RST = 17'd6;

    typedef struct packed {
        logic ready;
        logic load_sq;
        logic load_sc;
        logic step;
        logic finish;
    } ipd_cmd_t;

    typedef struct packed {
        logic last_taken;
        logic y_zero;
        logic out_free;
    } ipd_stat_t;

endpackage

`default_nettype wire

>>> design/ipd_in_if.sv
`default_nettype none

interface ipd_in_if import ipd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [STAMP_W-1:0] stamp;
    logic               last_event;

    modport source (output valid, stamp, last_event, input ready);
    modport sink   (input valid, stamp, last_event, output ready);
endinterface

`default_nettype wire

>>> design/ipd_out_if.sv
`default_nettype none

interface ipd_out_if import ipd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             periodic;
    logic [RUN_W-1:0] run_length;
    logic             too_long;

    modport source (output valid, periodic, run_length, too_long, input ready);
    modport sink   (input valid, periodic, run_length, too_long, output ready);
endinterface

`default_nettype wire

>>> design/ipd_ctrl.sv
`default_nettype none

module ipd_ctrl import ipd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  ipd_stat_t stat,
    output ipd_cmd_t  cmd
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_DRAIN = 6'b000010,
        ST_LOAD  = 6'b000100,
        ST_SQ    = 6'b001000,
        ST_SC    = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.ready = 1'b1;
                if (stat.last_taken)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                cmd.load_sq = 1'b1;
                state_next  = ST_SQ;
            end
            ST_SQ:
            begin
                if (stat.y_zero)
                begin
                    cmd.load_sc = 1'b1;
                    state_next  = ST_SC;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            ST_SC:
            begin
                if (stat.y_zero)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/ipd_datapath.sv
`default_nettype none

module ipd_datapath import ipd_pkg::*;
#(
    parameter int unsigned EVENT_LIMIT = EVENT_LIMIT_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [MIN_W-1:0] cfg_wr_data,
    ipd_in_if.sink           events,
    ipd_out_if.source        verdict,
    input  ipd_cmd_t         cmd,
    output ipd_stat_t        stat
);

    localparam int unsigned TW = $clog2(EVENT_LIMIT + 1);
    localparam int unsigned SW = STAMP_W + TW;
    localparam int unsigned QW = 2 * STAMP_W + TW;
    localparam int unsigned KW = TW + 5;
    localparam int unsigned PW = 2 * SW + 5;
    localparam int unsigned CW = (TW > MIN_W) ? TW : MIN_W;

    logic [MIN_W-1:0]     min_reg;
    logic [STAMP_W-1:0]   prior_reg;
    logic [TW-1:0]        tally_reg;
    logic                 ovf_reg;
    logic                 pend_reg;
    logic [SW-1:0]        sum_reg;
    logic [QW-1:0]        sq_sum_reg;
    logic [STAMP_W-1:0]   gap_reg;
    logic [2*STAMP_W-1:0] sq_reg;
    logic [PW-1:0]        x_reg;
    logic [SW-1:0]        y_reg;
    logic [PW-1:0]        acc_reg;
    logic [PW-1:0]        rhs_reg;
    logic                 out_valid_reg;
    logic                 periodic_reg;
    logic [RUN_W-1:0]     run_reg;
    logic                 too_long_reg;

    logic                 accept;
    logic                 at_max;
    logic [STAMP_W-1:0]   gap_next;
    logic [TW-1:0]        gaps;
    logic [KW-1:0]        k_next;
    logic [PW-1:0]        rhs_next;
    logic                 periodic_next;

    assign accept   = events.valid & cmd.ready;
    assign at_max   = tally_reg >= TW'(EVENT_LIMIT);
    assign gap_next = events.stamp - prior_reg;
    assign gaps     = tally_reg - TW'(1);
    assign k_next   = (KW'(gaps) << 4) + (KW'(gaps) << 3) + KW'(gaps);
    assign rhs_next = (acc_reg << 4) + (acc_reg << 3) + (acc_reg << 1);

    // lhs = 25*n*S2 sits in acc_reg, rhs = 26*S*S in rhs_reg
    assign periodic_next = !ovf_reg && (CW'(tally_reg) >= CW'(min_reg))
                           && (acc_reg < rhs_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg       <= MIN_EVENTS_RST;
            prior_reg     <= '0;
            tally_reg     <= '0;
            ovf_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            sum_reg       <= '0;
            sq_sum_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                min_reg <= cfg_wr_data;
            end
            pend_reg <= accept && !at_max && (tally_reg != '0);
            if (accept)
            begin
                if (at_max)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    tally_reg <= tally_reg + TW'(1);
                    prior_reg <= events.stamp;
                end
            end
            if (pend_reg)
            begin
                sum_reg    <= sum_reg + SW'(gap_reg);
                sq_sum_reg <= sq_sum_reg + QW'(sq_reg);
            end
            if (cmd.finish)
            begin
                prior_reg  <= '0;
                tally_reg  <= '0;
                ovf_reg    <= 1'b0;
                sum_reg    <= '0;
                sq_sum_reg <= '0;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (verdict.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        gap_reg <= gap_next;
        sq_reg  <= gap_next * gap_next;
        if (cmd.load_sq)
        begin
            x_reg   <= PW'(sum_reg);
            y_reg   <= sum_reg;
            acc_reg <= '0;
        end
        else if (cmd.load_sc)
        begin
            rhs_reg <= rhs_next;
            x_reg   <= PW'(sq_sum_reg);
            y_reg   <= SW'(k_next);
            acc_reg <= '0;
        end
        else if (cmd.step)
        begin
            acc_reg <= acc_reg + x_reg * PW'(y_reg[DIGIT_W-1:0]);
            x_reg   <= x_reg << DIGIT_W;
            y_reg   <= y_reg >> DIGIT_W;
        end
        if (cmd.finish)
        begin
            periodic_reg <= periodic_next;
            run_reg      <= RUN_W'(tally_reg);
            too_long_reg <= ovf_reg;
        end
    end

    assign events.ready       = cmd.ready;
    assign verdict.valid      = out_valid_reg;
    assign verdict.periodic   = periodic_reg;
    assign verdict.run_length = run_reg;
    assign verdict.too_long   = too_long_reg;

    assign stat.last_taken = accept & events.last_event;
    assign stat.y_zero     = (y_reg == '0);
    assign stat.out_free   = !out_valid_reg || verdict.ready;

endmodule

`default_nettype wire

>>> design/interval_periodicity_detector.sv
// Periodicity check over a run of event timestamps. Each request carries one
// 32-bit timestamp; last_event closes the run. Gaps (modulo 2^32) are
// squared and accumulated at one request per clock. After the closing request
// the block stops taking requests while it evaluates 25*n*S2 < 26*S*S on a
// shared 8-bit-digit multiplier, stepping through states DRAIN, LOAD, SQ,
// SC and DONE. The verdict is loaded in DONE once the previous verdict has
// been read, and requests are taken again from the cycle in which the new
// verdict appears. The verdict sits in an output register, so the next run
// may start while it waits. min_events is written through cfg_wr_en and
// cfg_wr_data; the user must do so only while idle (the block does not
// enforce it). A run longer than EVENT_LIMIT reports too_long, not periodic.
`default_nettype none

module interval_periodicity_detector import ipd_pkg::*;
#(
    parameter int unsigned EVENT_LIMIT = EVENT_LIMIT_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [MIN_W-1:0] cfg_wr_data,
    ipd_in_if.sink           events,
    ipd_out_if.source        verdict
);

    ipd_cmd_t  cmd;
    ipd_stat_t stat;

    ipd_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    ipd_datapath #(.EVENT_LIMIT(EVENT_LIMIT)) u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .events      (events),
        .verdict     (verdict),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

`default_nettype wire

>>> design/ipd_checker.sv
`default_nettype none

module ipd_checker import ipd_pkg::*;
#(
    parameter int unsigned EVENT_LIMIT = EVENT_LIMIT_DEF
)
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             in_last,
    input logic             out_valid,
    input logic             out_ready,
    input logic             out_periodic,
    input logic [RUN_W-1:0] out_run_length,
    input logic             out_too_long
);

    default disable iff (!rst_n);

    a_out_hold: assert property (@(posedge clk)
        out_valid && !out_ready |=> out_valid)
        else $error("verdict dropped before taken");

    a_long_not_periodic: assert property (@(posedge clk)
        out_valid |-> !(out_periodic && out_too_long))
        else $error("overlong run reported periodic");

    a_periodic_len: assert property (@(posedge clk)
        out_valid && out_periodic |-> out_run_length >= RUN_W'(2))
        else $error("periodic verdict with fewer than two events");

    a_long_len: assert property (@(posedge clk)
        out_valid && out_too_long |-> out_run_length == RUN_W'(EVENT_LIMIT))
        else $error("overlong run has wrong length");

    a_close_stall: assert property (@(posedge clk)
        in_valid && in_ready && in_last |=> !in_ready)
        else $error("request taken right after run closed");

endmodule

bind interval_periodicity_detector ipd_checker #(.EVENT_LIMIT(EVENT_LIMIT)) u_ipd_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (events.valid),
    .in_ready       (events.ready),
    .in_last        (events.last_event),
    .out_valid      (verdict.valid),
    .out_ready      (verdict.ready),
    .out_periodic   (verdict.periodic),
    .out_run_length (verdict.run_length),
    .out_too_long   (verdict.too_long)
);

`default_nettype wire
